/* sv/assert_macros.svh */
// Assertion macros used by the top RTL file of the joint controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* sv/smjc_pkg.sv */
// Types, register codes and helpers shared by the joint controller modules.
package smjc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_SLOPE = 3'd1;
    localparam logic [2:0] CFG_KSW   = 3'd2;
    localparam logic [2:0] CFG_PHI   = 3'd3;
    localparam logic [2:0] CFG_KD    = 3'd4;
    localparam logic [2:0] CFG_KI    = 3'd5;
    localparam logic [2:0] CFG_LIM   = 3'd6;
    localparam logic [2:0] CFG_DT    = 3'd7;

    // reset values of the registers
    localparam logic        RST_MODE  = 1'b0;
    localparam logic [30:0] RST_SLOPE = 31'd65536;
    localparam logic [30:0] RST_KSW   = 31'd0;
    localparam logic [30:0] RST_PHI   = 31'd65536;
    localparam logic [30:0] RST_KD    = 31'd0;
    localparam logic [30:0] RST_KI    = 31'd0;
    localparam logic [30:0] RST_LIM   = 31'd32768;
    localparam logic [15:0] RST_DT    = 16'd66;

    typedef struct packed {
        logic        mode;      // 1: motor runs the linear part
        logic [30:0] slope;     // lambda
        logic [30:0] k_sw;      // K
        logic [30:0] phi;       // boundary width
        logic [30:0] k_d;       // Kd
        logic [30:0] k_i;       // Ki
        logic [30:0] lim;       // integral clamp
        logic [15:0] dt;
    } t_cfg;

    // multiplier operand selection
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_SLOPE = 3'd0;
    localparam t_mul_sel MUL_DT    = 3'd1;
    localparam t_mul_sel MUL_KI    = 3'd2;
    localparam t_mul_sel MUL_KSW   = 3'd3;
    localparam t_mul_sel MUL_KD    = 3'd4;

    typedef struct packed {
        logic     load;       // capture input item, seed torque with feedforward
        logic     err;        // form e and de
        logic     surf;       // form s and |s|
        logic     integ;      // update integral, seed divider
        logic     div_step;   // one quotient bit
        logic     sw_fix;     // select switching term
        logic     acc_sub;    // torque -= product >> frac
        logic     out_load;   // move result into output register
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;       // last quotient bit this cycle
    } t_dp_stat;

    localparam logic signed [63:0] S32_MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN64 = 64'shFFFF_FFFF_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX64) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN64) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/smjc_dp.sv */
// Datapath of the joint controller: errors, surface, integral, divider, torque.
module smjc_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  smjc_pkg::t_cfg         i_cfg,
    input  smjc_pkg::t_dp_cmd      i_cmd,
    input  logic signed [31:0]     i_q,
    input  logic signed [31:0]     i_dq,
    input  logic signed [31:0]     i_qd,
    input  logic signed [31:0]     i_dqd,
    input  logic signed [31:0]     i_ff,
    output smjc_pkg::t_dp_stat     o_stat,
    output logic signed [31:0]     o_tau,
    output logic signed [31:0]     o_e,
    output logic signed [31:0]     o_s,
    output logic signed [31:0]     o_prf,
    output logic signed [31:0]     o_vrf
);

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] r_q, r_dq, r_qd, r_dqd;
    logic signed [31:0] r_e, r_de, r_s, r_sw, r_integ;
    logic        [31:0] r_mag, r_rem;
    logic               r_in_band;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [63:0] r_prod, r_tau;

    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod_sh, w_acc, w_lim, w_integ;
    logic signed [31:0] w_s, w_quo;
    logic        [32:0] w_rem_sh, w_phi33;
    logic               w_ge;

    // shared multiplier, product always registered
    always_comb begin
        unique case (i_cmd.mul_sel)
            smjc_pkg::MUL_SLOPE: begin
                w_mul_a = $signed({1'b0, i_cfg.slope});
                w_mul_b = r_e;
            end
            smjc_pkg::MUL_DT: begin
                w_mul_a = $signed({16'd0, i_cfg.dt});
                w_mul_b = r_s;
            end
            smjc_pkg::MUL_KI: begin
                w_mul_a = $signed({1'b0, i_cfg.k_i});
                w_mul_b = r_integ;
            end
            smjc_pkg::MUL_KSW: begin
                w_mul_a = $signed({1'b0, i_cfg.k_sw});
                w_mul_b = r_sw;
            end
            smjc_pkg::MUL_KD: begin
                w_mul_a = $signed({1'b0, i_cfg.k_d});
                w_mul_b = r_s;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // arithmetic shift floors, as the control law expects
    assign w_prod_sh = r_prod >>> FRAC_BITS;
    assign w_s       = smjc_pkg::sat32(64'(r_de) + w_prod_sh);

    // integral step and clamp
    assign w_lim = $signed({33'd0, i_cfg.lim});
    assign w_acc = 64'(r_integ) + (r_in_band ? w_prod_sh : 64'sd0);
    always_comb begin
        if (w_acc < -w_lim) begin
            w_integ = -w_lim;
        end else if (w_acc > w_lim) begin
            w_integ = w_lim;
        end else begin
            w_integ = w_acc;
        end
    end

    // restoring divider, |s| < phi so the remainder stays below 2^31
    assign w_rem_sh = {r_rem, 1'b0};
    assign w_phi33  = {2'b00, i_cfg.phi};
    assign w_ge     = w_rem_sh >= w_phi33;
    assign w_quo    = $signed({{(32-FRAC_BITS){1'b0}}, r_quo});

    assign o_stat.div_last = (r_cnt == CNT_W'(FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        r_prod    <= w_mul_a * w_mul_b;
        r_in_band <= r_mag < {1'b0, i_cfg.phi};
        if (i_cmd.load) begin
            r_q   <= i_q;
            r_dq  <= i_dq;
            r_qd  <= i_qd;
            r_dqd <= i_dqd;
            r_tau <= 64'(i_ff);
        end
        if (i_cmd.err) begin
            r_e  <= smjc_pkg::sat32(64'(r_q) - 64'(r_qd));
            r_de <= smjc_pkg::sat32(64'(r_dq) - 64'(r_dqd));
        end
        if (i_cmd.surf) begin
            r_s   <= w_s;
            r_mag <= w_s[31] ? (~w_s + 32'd1) : w_s;
        end
        if (i_cmd.integ) begin
            r_rem <= r_mag;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? 32'(w_rem_sh - w_phi33) : w_rem_sh[31:0];
            r_quo <= {r_quo[FRAC_BITS-2:0], w_ge};
        end
        if (i_cmd.sw_fix) begin
            if (r_in_band) begin
                r_sw <= r_s[31] ? -w_quo : w_quo;
            end else if (r_s[31]) begin
                r_sw <= -ONE;
            end else if (r_s == 32'sd0) begin
                r_sw <= 32'sd0;
            end else begin
                r_sw <= ONE;
            end
        end
        if (i_cmd.acc_sub) begin
            r_tau <= r_tau - w_prod_sh;
        end
        if (i_cmd.out_load) begin
            o_tau <= smjc_pkg::sat32(r_tau);
            o_e   <= r_e;
            o_s   <= r_s;
            o_prf <= i_cfg.mode ? r_qd : 32'sd0;
            o_vrf <= i_cfg.mode ? r_dqd : 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.integ && (i_cfg.k_i != 31'd0)) begin
                r_integ <= w_integ[31:0];
            end
            if (i_cmd.integ) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

/* sv/smjc_ctrl.sv */
// Sequencer of the joint controller: steps the datapath and owns the handshakes.
module smjc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    input  logic                  i_motor_mode,
    input  smjc_pkg::t_dp_stat    i_stat,
    output smjc_pkg::t_dp_cmd     o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_MSLP  = 4'd2;
    localparam logic [3:0] ST_SURF  = 4'd3;
    localparam logic [3:0] ST_MDT   = 4'd4;
    localparam logic [3:0] ST_INTEG = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SIGN  = 4'd7;
    localparam logic [3:0] ST_MKI   = 4'd8;
    localparam logic [3:0] ST_AKI   = 4'd9;
    localparam logic [3:0] ST_ASW   = 4'd10;
    localparam logic [3:0] ST_AKD   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = smjc_pkg::MUL_SLOPE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ERR;
                end
            end
            ST_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = ST_MSLP;
            end
            ST_MSLP: begin
                o_cmd.mul_sel = smjc_pkg::MUL_SLOPE;
                n_state       = ST_SURF;
            end
            ST_SURF: begin
                o_cmd.surf = 1'b1;
                n_state    = ST_MDT;
            end
            ST_MDT: begin
                o_cmd.mul_sel = smjc_pkg::MUL_DT;
                n_state       = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                o_cmd.sw_fix = 1'b1;
                n_state      = ST_MKI;
            end
            ST_MKI: begin
                o_cmd.mul_sel = smjc_pkg::MUL_KI;
                n_state       = ST_AKI;
            end
            ST_AKI: begin
                // switching product overlaps the integral subtract
                o_cmd.acc_sub = 1'b1;
                o_cmd.mul_sel = smjc_pkg::MUL_KSW;
                n_state       = i_motor_mode ? ST_OUT : ST_ASW;
            end
            ST_ASW: begin
                o_cmd.acc_sub = 1'b1;
                o_cmd.mul_sel = smjc_pkg::MUL_KD;
                n_state       = ST_AKD;
            end
            ST_AKD: begin
                o_cmd.acc_sub = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

/* sv/sliding_mode_joint_controller.sv */
// Sliding-mode controller for one joint: config registers, sequencer and datapath.
//
// Use: one instance per joint. Write the gains on the cfg channel (index 0..7,
// always ready) while the block is idle. Each item on s_axis carries the
// measured and target position and velocity and the feedforward torque; the
// result on m_axis carries torque, position error, surface and the two
// references (zero in host mode).
// Timing: one item at a time. How long an item occupies the block is set by the
// bit-serial divider for s/phi (one quotient bit per cycle) and the single
// shared 32x32 multiplier; motor mode skips the switching and Kd torque steps.
// The result appears on m_axis in the cycle after its last step; s_axis_tready
// rises again in that same cycle.
// Stall: the output register holds a finished result while the next item is
// taken and worked; only when that next result is done and the old one is still
// not taken does the block wait, with s_axis_tready low.
// Reset: synchronous, active low; clears the sequencer, the output valid, the
// integral and loads the register defaults.
`include "assert_macros.svh"
module sliding_mode_joint_controller #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint_position, joint_velocity, target_position, target_velocity,
    // feedforward_torque (32 bits each, from bit 0)
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // drive_torque, position_error, surface_value, position_reference,
    // velocity_reference (32 bits each, from bit 0)
    output logic [159:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    smjc_pkg::t_cfg     r_cfg;
    smjc_pkg::t_dp_cmd  w_cmd;
    smjc_pkg::t_dp_stat w_stat;
    logic signed [31:0] w_tau, w_e, w_s, w_prf, w_vrf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= smjc_pkg::RST_MODE;
            r_cfg.slope <= smjc_pkg::RST_SLOPE;
            r_cfg.k_sw  <= smjc_pkg::RST_KSW;
            r_cfg.phi   <= smjc_pkg::RST_PHI;
            r_cfg.k_d   <= smjc_pkg::RST_KD;
            r_cfg.k_i   <= smjc_pkg::RST_KI;
            r_cfg.lim   <= smjc_pkg::RST_LIM;
            r_cfg.dt    <= smjc_pkg::RST_DT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smjc_pkg::CFG_MODE:  r_cfg.mode  <= i_cfg_data[0];
                smjc_pkg::CFG_SLOPE: r_cfg.slope <= i_cfg_data[30:0];
                smjc_pkg::CFG_KSW:   r_cfg.k_sw  <= i_cfg_data[30:0];
                smjc_pkg::CFG_PHI:   r_cfg.phi   <= i_cfg_data[30:0];
                smjc_pkg::CFG_KD:    r_cfg.k_d   <= i_cfg_data[30:0];
                smjc_pkg::CFG_KI:    r_cfg.k_i   <= i_cfg_data[30:0];
                smjc_pkg::CFG_LIM:   r_cfg.lim   <= i_cfg_data[30:0];
                smjc_pkg::CFG_DT:    r_cfg.dt    <= i_cfg_data[15:0];
            endcase
        end
    end

    smjc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_motor_mode (r_cfg.mode),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    smjc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_cmd),
        .i_q     ($signed(s_axis_tdata[31:0])),
        .i_dq    ($signed(s_axis_tdata[63:32])),
        .i_qd    ($signed(s_axis_tdata[95:64])),
        .i_dqd   ($signed(s_axis_tdata[127:96])),
        .i_ff    ($signed(s_axis_tdata[159:128])),
        .o_stat  (w_stat),
        .o_tau   (w_tau),
        .o_e     (w_e),
        .o_s     (w_s),
        .o_prf   (w_prf),
        .o_vrf   (w_vrf)
    );

    assign m_axis_tdata = {w_vrf, w_prf, w_s, w_e, w_tau};

    // a waiting result is never overwritten
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, (w_cmd.out_load && m_axis_tvalid) |-> m_axis_tready, "result overwritten before taken")
    // loading a result always presents it next cycle
    `ASSERT_IMPLY(a_out_follows, i_clk, i_rst_n, w_cmd.out_load |=> m_axis_tvalid, "loaded result not presented")
    // taking an item and finishing one never share a cycle
    `ASSERT_NEVER(a_load_vs_out, i_clk, i_rst_n, s_axis_tready && w_cmd.out_load, "input taken while result loads")

endmodule
